// ===== rtl/core/plps_pkg.sv =====
// Shared types, codes and constants of the process limit and profile sequencer.
package plps_pkg;

    localparam int unsigned DefProfileDepth = 16;
    localparam logic [15:0] GRACE_TICKS     = 16'd5;

    // opcodes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    // limit modes
    localparam logic [1:0] LIM_NONE      = 2'd0;
    localparam logic [1:0] LIM_FREQ_TIME = 2'd1;
    localparam logic [1:0] LIM_FREQ      = 2'd2;
    localparam logic [1:0] LIM_TIME      = 2'd3;

    // process modes
    localparam logic [1:0] PM_CONTINUE = 2'd0;
    localparam logic [1:0] PM_INTERVAL = 2'd1;
    localparam logic [1:0] PM_PROGRAM  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_LIMIT_MODE   = 3'd0;
    localparam logic [2:0] REG_PROCESS_MODE = 3'd1;
    localparam logic [2:0] REG_LOWER_FREQ   = 3'd2;
    localparam logic [2:0] REG_UPPER_TIME   = 3'd3;
    localparam logic [2:0] REG_ON_TICKS     = 3'd4;
    localparam logic [2:0] REG_OFF_TICKS    = 3'd5;
    localparam logic [2:0] REG_DELAY_START  = 3'd6;

    typedef struct packed {
        logic [1:0]  limit_mode;
        logic [1:0]  process_mode;
        logic [15:0] lower_freq_limit;
        logic [15:0] upper_time_limit;
        logic [15:0] on_ticks;
        logic [15:0] off_ticks;
        logic [15:0] delay_start_ticks;
    } t_cfg;

    typedef struct packed {
        logic [15:0] step_duration;
        logic [11:0] step_amplitude;
        logic [15:0] frequency;
        logic [15:0] elapsed_time;
        logic        machine_ready;
        logic [1:0]  opcode;
    } t_item;

    typedef struct packed {
        logic        profile_overflow;
        logic        sonics_on;
        logic [11:0] amplitude_value;
        logic        amplitude_write;
        logic [1:0]  run_command;
        logic        limit_ok;
    } t_result;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_prof_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_prof_sts;

endpackage

// ===== rtl/core/plps_cfg.sv =====
// Configuration register file.
module plps_cfg
    import plps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit_mode        <= LIM_NONE;
            r_cfg.process_mode      <= PM_CONTINUE;
            r_cfg.lower_freq_limit  <= 16'd0;
            r_cfg.upper_time_limit  <= 16'hFFFF;
            r_cfg.on_ticks          <= 16'd1;
            r_cfg.off_ticks         <= 16'd1;
            r_cfg.delay_start_ticks <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LIMIT_MODE:   r_cfg.limit_mode        <= i_cfg_data[1:0];
                REG_PROCESS_MODE: r_cfg.process_mode      <= i_cfg_data[1:0];
                REG_LOWER_FREQ:   r_cfg.lower_freq_limit  <= i_cfg_data;
                REG_UPPER_TIME:   r_cfg.upper_time_limit  <= i_cfg_data;
                REG_ON_TICKS:     r_cfg.on_ticks          <= i_cfg_data;
                REG_OFF_TICKS:    r_cfg.off_ticks         <= i_cfg_data;
                REG_DELAY_START:  r_cfg.delay_start_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/plps_prof.sv =====
// Profile step FIFO with a prefetched head entry.
module plps_prof
    import plps_pkg::*;
#(
    parameter int unsigned PROFILE_DEPTH = DefProfileDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_prof_ctl   i_ctl,
    input  logic [11:0] i_wr_amp,
    input  logic [15:0] i_wr_dur,
    output t_prof_sts   o_sts,
    output logic [11:0] o_head_amp,
    output logic [15:0] o_head_dur
);

    localparam int unsigned HW = (PROFILE_DEPTH > 1) ? $clog2(PROFILE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(PROFILE_DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    logic [27:0]   mem [PROFILE_DEPTH];
    logic [HW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [27:0]   r_rd;
    logic [SW-1:0] wsum;
    logic [HW-1:0] waddr;
    logic [27:0]   wdata;

    assign wdata = {i_wr_amp, i_wr_dur};
    assign wsum  = SW'(r_head) + SW'(r_count);

    always_comb begin
        if (wsum >= SW'(PROFILE_DEPTH)) begin
            waddr = HW'(wsum - SW'(PROFILE_DEPTH));
        end else begin
            waddr = HW'(wsum);
        end
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctl.clear) begin
            n_head  = '0;
            n_count = '0;
        end else if (i_ctl.pop) begin
            n_head  = (r_head == HW'(PROFILE_DEPTH - 1)) ? '0 : r_head + HW'(1);
            n_count = r_count - CW'(1);
        end else if (i_ctl.push) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[waddr] <= wdata;
        end
    end

    // read next head now so it is ready for the following beat; write-first bypass
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && (waddr == n_head)) begin
            r_rd <= wdata;
        end else begin
            r_rd <= mem[n_head];
        end
    end

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == CW'(PROFILE_DEPTH));
    assign o_head_amp  = r_rd[27:16];
    assign o_head_dur  = r_rd[15:0];

endmodule

// ===== rtl/core/plps_ctrl.sv =====
// Limit check, interval and program sequencing for one item.
module plps_ctrl
    import plps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_item       i_item,
    input  t_cfg        i_cfg,
    input  t_prof_sts   i_prof_sts,
    input  logic [11:0] i_head_amp,
    input  logic [15:0] i_head_dur,
    output t_prof_ctl   o_prof_ctl,
    output t_result     o_result
);

    logic [15:0] r_run_cd, n_run_cd;
    logic [15:0] r_pause_cd, n_pause_cd;
    logic [15:0] r_delay_cd, n_delay_cd;
    logic        r_sonics, n_sonics;

    logic chk_f, chk_t, pass;
    logic run, stop, aw, ovf;
    logic [11:0] av;
    logic [15:0] run_dec, pause_dec;
    t_prof_ctl ctl;

    assign chk_f = (i_cfg.limit_mode == LIM_FREQ_TIME) || (i_cfg.limit_mode == LIM_FREQ);
    assign chk_t = (i_cfg.limit_mode == LIM_FREQ_TIME) || (i_cfg.limit_mode == LIM_TIME);
    assign pass  = !(chk_f && (i_item.elapsed_time > GRACE_TICKS)
                     && (i_item.frequency < i_cfg.lower_freq_limit))
                && !(chk_t && (i_item.elapsed_time > i_cfg.upper_time_limit));
    assign run_dec   = r_run_cd - 16'd1;
    assign pause_dec = r_pause_cd - 16'd1;

    always_comb begin
        n_run_cd   = r_run_cd;
        n_pause_cd = r_pause_cd;
        n_delay_cd = r_delay_cd;
        n_sonics   = r_sonics;
        run        = 1'b0;
        stop       = 1'b0;
        aw         = 1'b0;
        av         = '0;
        ovf        = 1'b0;
        ctl        = '0;
        case (i_item.opcode)
            OP_APPEND: begin
                if (i_prof_sts.full) begin
                    ovf = 1'b1;
                end else begin
                    ctl.push = 1'b1;
                end
            end
            OP_START: begin
                ctl.clear  = 1'b1;
                n_delay_cd = i_cfg.delay_start_ticks;
                n_pause_cd = i_cfg.off_ticks;
                n_run_cd   = (i_cfg.process_mode == PM_PROGRAM) ? 16'd0 : i_cfg.on_ticks;
                n_sonics   = 1'b0;
            end
            OP_TICK: begin
                if (!pass) begin
                    stop = 1'b1;
                end else if (i_cfg.process_mode == PM_INTERVAL) begin
                    if (!i_item.machine_ready) begin
                        n_run_cd = run_dec;
                        if (run_dec == 16'd0) begin
                            stop     = 1'b1;
                            n_run_cd = i_cfg.on_ticks;
                            n_sonics = 1'b0;
                        end
                    end else begin
                        n_pause_cd = pause_dec;
                        if (pause_dec == 16'd0) begin
                            run        = 1'b1;
                            n_pause_cd = i_cfg.off_ticks;
                            n_sonics   = 1'b1;
                        end
                    end
                end else if (i_cfg.process_mode == PM_PROGRAM) begin
                    if (r_delay_cd != 16'd0) begin
                        n_delay_cd = r_delay_cd - 16'd1;
                    end else if (i_item.machine_ready) begin
                        run = 1'b1;
                    end
                    if (r_run_cd == 16'd0) begin
                        if (!i_prof_sts.empty) begin
                            aw       = 1'b1;
                            av       = i_head_amp;
                            n_run_cd = i_head_dur;
                            ctl.pop  = 1'b1;
                        end else begin
                            stop = 1'b1;
                        end
                    end else begin
                        if (i_item.machine_ready) begin
                            run = 1'b1;
                        end
                        n_run_cd = run_dec;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_cd   <= '0;
            r_pause_cd <= '0;
            r_delay_cd <= '0;
            r_sonics   <= 1'b0;
        end else if (i_fire) begin
            r_run_cd   <= n_run_cd;
            r_pause_cd <= n_pause_cd;
            r_delay_cd <= n_delay_cd;
            r_sonics   <= n_sonics;
        end
    end

    assign o_prof_ctl.clear = i_fire && ctl.clear;
    assign o_prof_ctl.push  = i_fire && ctl.push;
    assign o_prof_ctl.pop   = i_fire && ctl.pop;

    assign o_result.limit_ok         = (i_item.opcode == OP_TICK) && pass;
    assign o_result.run_command      = {stop, run};
    assign o_result.amplitude_write  = aw;
    assign o_result.amplitude_value  = av;
    assign o_result.sonics_on        = n_sonics;
    assign o_result.profile_overflow = ovf;

endmodule

// ===== rtl/core/process_limit_and_profile_sequencer_top.sv =====
// Top level of the process limit and profile sequencer.
// Takes one beat per clock while the output is not stalled and returns one
// result beat for every input beat: an input register feeds the limit check
// and sequencing logic, whose result lands in an output register. The profile
// store is a PROFILE_DEPTH-entry memory whose head entry is read ahead into a
// register, so a tick right after an append or a pop still sees the right step.
// The opcode travels in s_axis_tuser. The user must write configuration through
// i_cfg_we/i_cfg_addr/i_cfg_data only while no beats are in flight; the block does not enforce it.
module process_limit_and_profile_sequencer_top
    import plps_pkg::*;
#(
    parameter int unsigned PROFILE_DEPTH = DefProfileDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] machine_ready, [16:1] elapsed_time, [32:17] frequency,
    // [44:33] step_amplitude, [60:45] step_duration, [63:61] zero
    input  logic [63:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] limit_ok, [2:1] run_command, [3] amplitude_write,
    // [15:4] amplitude_value, [16] sonics_on, [17] profile_overflow, [23:18] zero
    output logic [23:0] m_axis_tdata
);

    t_cfg        cfg;
    t_prof_ctl   prof_ctl;
    t_prof_sts   prof_sts;
    logic [11:0] head_amp;
    logic [15:0] head_dur;
    t_result     result;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    fire;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= {s_axis_tdata[60:0], s_axis_tuser};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    plps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    plps_prof #(
        .PROFILE_DEPTH (PROFILE_DEPTH)
    ) u_prof (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (prof_ctl),
        .i_wr_amp   (r_in.step_amplitude),
        .i_wr_dur   (r_in.step_duration),
        .o_sts      (prof_sts),
        .o_head_amp (head_amp),
        .o_head_dur (head_dur)
    );

    plps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (r_in),
        .i_cfg      (cfg),
        .i_prof_sts (prof_sts),
        .i_head_amp (head_amp),
        .i_head_dur (head_dur),
        .o_prof_ctl (prof_ctl),
        .o_result   (result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out};

endmodule

// ===== sim/tb_process_limit_and_profile_sequencer_top.sv =====
// Self-checking testbench for the process limit and profile sequencer top level.
module tb_process_limit_and_profile_sequencer_top
    import plps_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [1:0] PM_HOLD      = 2'd3;
    localparam logic [1:0] CMD_RUN_STOP = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    process_limit_and_profile_sequencer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor copy of configuration and sequencer state
    t_cfg        cfg;
    logic [27:0] prof_mem [DefProfileDepth];
    int          prof_rd;
    int          prof_fill;
    logic [15:0] run_cnt;
    logic [15:0] pause_cnt;
    logic [15:0] delay_cnt;
    logic        sonic;

    t_result pending_results[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int n_useful;
    int n_tick, n_append, n_start, n_unused;
    int n_refused, n_run_stop, n_amp_writes;
    int n_checked;
    int n_errors;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400us;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic t_result sequencer_step(input t_item it);
        t_result     r;
        logic        run;
        logic        stop;
        logic        chk_f;
        logic        chk_t;
        logic [27:0] entry;
        r     = '0;
        run   = 1'b0;
        stop  = 1'b0;
        chk_f = (cfg.limit_mode == LIM_FREQ_TIME) || (cfg.limit_mode == LIM_FREQ);
        chk_t = (cfg.limit_mode == LIM_FREQ_TIME) || (cfg.limit_mode == LIM_TIME);
        case (it.opcode)
            OP_APPEND: begin
                if (prof_fill >= DefProfileDepth) begin
                    r.profile_overflow = 1'b1;
                end else begin
                    prof_mem[(prof_rd + prof_fill) % DefProfileDepth] =
                        {it.step_amplitude, it.step_duration};
                    prof_fill++;
                end
            end
            OP_START: begin
                prof_rd   = 0;
                prof_fill = 0;
                delay_cnt = cfg.delay_start_ticks;
                pause_cnt = cfg.off_ticks;
                run_cnt   = (cfg.process_mode == PM_PROGRAM) ? 16'd0 : cfg.on_ticks;
                sonic     = 1'b0;
            end
            OP_TICK: begin
                if ((chk_f && it.elapsed_time > GRACE_TICKS
                        && it.frequency < cfg.lower_freq_limit)
                        || (chk_t && it.elapsed_time > cfg.upper_time_limit)) begin
                    stop = 1'b1;
                end else begin
                    r.limit_ok = 1'b1;
                    case (cfg.process_mode)
                        PM_INTERVAL: begin
                            // both countdowns decrement before the zero test
                            if (!it.machine_ready) begin
                                run_cnt = run_cnt - 16'd1;
                                if (run_cnt == 16'd0) begin
                                    stop    = 1'b1;
                                    run_cnt = cfg.on_ticks;
                                    sonic   = 1'b0;
                                end
                            end else begin
                                pause_cnt = pause_cnt - 16'd1;
                                if (pause_cnt == 16'd0) begin
                                    run       = 1'b1;
                                    pause_cnt = cfg.off_ticks;
                                    sonic     = 1'b1;
                                end
                            end
                        end
                        PM_PROGRAM: begin
                            if (delay_cnt != 16'd0) delay_cnt = delay_cnt - 16'd1;
                            else if (it.machine_ready) run = 1'b1;
                            if (run_cnt == 16'd0) begin
                                if (prof_fill > 0) begin
                                    entry             = prof_mem[prof_rd];
                                    r.amplitude_write = 1'b1;
                                    r.amplitude_value = entry[27:16];
                                    run_cnt           = entry[15:0];
                                    prof_rd           = (prof_rd + 1) % DefProfileDepth;
                                    prof_fill--;
                                end else begin
                                    stop = 1'b1;
                                end
                            end else begin
                                if (it.machine_ready) run = 1'b1;
                                run_cnt = run_cnt - 16'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        r.run_command = {stop, run};
        r.sonics_on   = sonic;
        return r;
    endfunction

    // result monitor: compares every output beat against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[17:0]);
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%0t: result beat %h with nothing expected", $realtime, got);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.limit_ok !== want.limit_ok
                        || got.run_command !== want.run_command
                        || got.amplitude_write !== want.amplitude_write
                        || got.amplitude_value !== want.amplitude_value
                        || got.sonics_on !== want.sonics_on
                        || got.profile_overflow !== want.profile_overflow) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"%0t: result %0d mismatch ok/cmd/aw/amp/son/ovf",
                                  " exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d"},
                                 $realtime, n_checked,
                                 want.limit_ok, want.run_command, want.amplitude_write,
                                 want.amplitude_value, want.sonics_on, want.profile_overflow,
                                 got.limit_ok, got.run_command, got.amplitude_write,
                                 got.amplitude_value, got.sonics_on, got.profile_overflow);
                end
            end
        end
    end

    task automatic send_beat(input t_item it);
        t_result r;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {3'b000, it.step_duration, it.step_amplitude, it.frequency,
                         it.elapsed_time, it.machine_ready};
        s_axis_tuser  = it.opcode;
        do @(posedge i_clk); while (!s_axis_tready);
        r = sequencer_step(it);
        pending_results.push_back(r);
        case (it.opcode)
            OP_TICK:   n_tick++;
            OP_APPEND: n_append++;
            OP_START:  n_start++;
            default:   n_unused++;
        endcase
        if (it.opcode != OP_UNUSED) n_useful++;
        if (r.profile_overflow) n_refused++;
        if (r.run_command == CMD_RUN_STOP) n_run_stop++;
        if (r.amplitude_write) n_amp_writes++;
        @(negedge i_clk);
    endtask

    // every beat yields a result, so an empty queue means the pipeline is idle
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        @(negedge i_clk);
    endtask

    task automatic set_config(input t_cfg c);
        drain();
        write_reg(REG_LIMIT_MODE, {14'd0, c.limit_mode});
        write_reg(REG_PROCESS_MODE, {14'd0, c.process_mode});
        write_reg(REG_LOWER_FREQ, c.lower_freq_limit);
        write_reg(REG_UPPER_TIME, c.upper_time_limit);
        write_reg(REG_ON_TICKS, c.on_ticks);
        write_reg(REG_OFF_TICKS, c.off_ticks);
        write_reg(REG_DELAY_START, c.delay_start_ticks);
        i_cfg_we = 1'b0;
        cfg = c;
    endtask

    function automatic t_cfg make_cfg(input logic [1:0] lm, input logic [1:0] pm,
                                      input logic [15:0] lo, input logic [15:0] up,
                                      input logic [15:0] on, input logic [15:0] off,
                                      input logic [15:0] dly);
        t_cfg c;
        c.limit_mode        = lm;
        c.process_mode      = pm;
        c.lower_freq_limit  = lo;
        c.upper_time_limit  = up;
        c.on_ticks          = on;
        c.off_ticks         = off;
        c.delay_start_ticks = dly;
        return c;
    endfunction

    function automatic t_item make_item(input logic [1:0] op, input logic rdy,
                                        input logic [15:0] et, input logic [15:0] fq,
                                        input logic [11:0] amp, input logic [15:0] dur);
        t_item it;
        it.opcode         = op;
        it.machine_ready  = rdy;
        it.elapsed_time   = et;
        it.frequency      = fq;
        it.step_amplitude = amp;
        it.step_duration  = dur;
        return it;
    endfunction

    function automatic t_item any_item();
        return make_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 16'($urandom),
                         16'($urandom), 12'($urandom), 16'($urandom));
    endfunction

    function automatic logic [15:0] near16(input logic [15:0] v, input int lo, input int hi);
        int x;
        x = int'(v) + lo + int'($urandom_range(0, hi - lo));
        if (x < 0) x = 0;
        if (x > 65535) x = 65535;
        return 16'(x);
    endfunction

    function automatic t_item tick_item();
        t_item it;
        it        = any_item();
        it.opcode = OP_TICK;
        case ($urandom_range(0, 3))
            0, 1: it.elapsed_time = 16'($urandom_range(0, 10));
            2:    it.elapsed_time = near16(cfg.upper_time_limit, -2, 2);
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0, 1: it.frequency = near16(cfg.lower_freq_limit, 0, 3);
            2:    it.frequency = near16(cfg.lower_freq_limit, -2, 2);
            default: ;
        endcase
        return it;
    endfunction

    function automatic t_item append_item();
        t_item it;
        it        = any_item();
        it.opcode = OP_APPEND;
        // short steps keep the profile moving
        if ($urandom_range(0, 7) != 0) it.step_duration = 16'($urandom_range(0, 3));
        return it;
    endfunction

    function automatic logic [15:0] pick_limit(input int hi);
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, hi));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        int   pm;
        pm             = $urandom_range(0, 99);
        c.limit_mode   = 2'($urandom_range(0, 3));
        c.process_mode = (pm < 40) ? PM_PROGRAM : (pm < 75) ? PM_INTERVAL :
                         (pm < 87) ? PM_CONTINUE : PM_HOLD;
        c.lower_freq_limit  = pick_limit(20);
        c.upper_time_limit  = pick_limit(40);
        c.on_ticks          = pick_count();
        c.off_ticks         = pick_count();
        c.delay_start_ticks = pick_count();
        return c;
    endfunction

    // start, a profile fill, then mostly ticks with some appends, restarts and junk
    task automatic random_segment();
        t_item it;
        int    len;
        int    pick;
        set_config(rand_cfg());
        it        = any_item();
        it.opcode = OP_START;
        send_beat(it);
        repeat ($urandom_range(0, 18)) send_beat(append_item());
        len = $urandom_range(15, 50);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_beat(any_item());
            end else if (pick < 14) begin
                send_beat(append_item());
            end else if (pick < 16) begin
                it        = any_item();
                it.opcode = OP_START;
                send_beat(it);
            end else begin
                send_beat(tick_item());
            end
        end
    endtask

    task automatic test_program_profile();
        set_config(make_cfg(LIM_FREQ_TIME, PM_PROGRAM, 16'd100, 16'd1000,
                            16'd0, 16'd0, 16'd1));
        send_beat(make_item(OP_START, 1'b0, 16'd0, 16'd0, 12'd0, 16'd0));
        send_beat(make_item(OP_APPEND, 1'b0, 16'd0, 16'd0, 12'hFFF, 16'd0));
        send_beat(make_item(OP_APPEND, 1'b1, 16'hFFFF, 16'hFFFF, 12'd0, 16'd1));
        // inside grace: low frequency still passes
        send_beat(make_item(OP_TICK, 1'b1, 16'd0, 16'd0, 12'd0, 16'd0));
        send_beat(make_item(OP_TICK, 1'b1, 16'd5, 16'd0, 12'd0, 16'd0));
        send_beat(make_item(OP_TICK, 1'b1, 16'd6, 16'd0, 12'd0, 16'd0));
        send_beat(make_item(OP_TICK, 1'b1, 16'd1001, 16'hFFFF, 12'd0, 16'd0));
        send_beat(make_item(OP_TICK, 1'b1, 16'd1000, 16'd100, 12'd0, 16'd0));
        // empty profile with run: run then stop
        send_beat(make_item(OP_TICK, 1'b1, 16'd1000, 16'd100, 12'd0, 16'd0));
        send_beat(make_item(OP_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF, 12'hFFF, 16'hFFFF));
    endtask

    task automatic test_interval_wrap();
        set_config(make_cfg(LIM_NONE, PM_INTERVAL, 16'd0, 16'hFFFF,
                            16'd0, 16'd1, 16'd0));
        send_beat(make_item(OP_START, 1'b1, 16'd0, 16'd0, 12'd0, 16'd0));
        send_beat(make_item(OP_TICK, 1'b1, 16'd0, 16'd0, 12'd0, 16'd0));
        // run countdown loaded with zero wraps instead of stopping
        send_beat(make_item(OP_TICK, 1'b0, 16'd0, 16'd0, 12'd0, 16'd0));
    endtask

    task automatic test_hold_mode_limits();
        set_config(make_cfg(LIM_FREQ, PM_HOLD, 16'hFFFF, 16'd0,
                            16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_beat(make_item(OP_TICK, 1'b0, 16'd6, 16'hFFFE, 12'd0, 16'd0));
        send_beat(make_item(OP_TICK, 1'b1, 16'hFFFF, 16'hFFFF, 12'hFFF, 16'hFFFF));
    endtask

    task automatic test_profile_full();
        t_item it;
        set_config(make_cfg(LIM_TIME, PM_PROGRAM, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0));
        send_beat(make_item(OP_START, 1'b0, 16'd0, 16'd0, 12'd0, 16'd0));
        // one more append than the store holds
        repeat (DefProfileDepth + 1) send_beat(append_item());
        it        = tick_item();
        it.elapsed_time = 16'd1;
        send_beat(it);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        int target;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target      = n_useful + count;
        while (n_useful < target) random_segment();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_LIMIT_MODE;
        i_cfg_data    = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 64'd0;
        s_axis_tuser  = OP_TICK;
        tx_idle_pct   = 18;
        rx_idle_pct   = 45;
        n_useful = 0; n_tick = 0; n_append = 0; n_start = 0; n_unused = 0;
        n_refused = 0; n_run_stop = 0; n_amp_writes = 0; n_checked = 0; n_errors = 0;
        cfg = make_cfg(LIM_NONE, PM_CONTINUE, 16'd0, 16'hFFFF, 16'd1, 16'd1, 16'd0);
        foreach (prof_mem[i]) prof_mem[i] = '0;
        prof_rd   = 0;
        prof_fill = 0;
        run_cnt   = '0;
        pause_cnt = '0;
        delay_cnt = '0;
        sonic     = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_program_profile();
        test_interval_wrap();
        test_hold_mode_limits();
        test_profile_full();
        test_random_traffic(18, 45, 380);
        test_random_traffic(45, 18, 380);
        test_random_traffic(0, 0, 380);

        s_axis_tvalid = 1'b0;
        for (int w = 0; w < 2000 && pending_results.size() != 0; w++) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            n_errors += pending_results.size();
        end

        $display("sent %0d ticks, %0d appends (%0d refused), %0d starts, %0d unused opcodes",
                 n_tick, n_append, n_refused, n_start, n_unused);
        $display("checked %0d results: %0d amplitude writes, %0d run-then-stop, %0d errors",
                 n_checked, n_amp_writes, n_run_stop, n_errors);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
